[src/lss_pkg.sv]
`timescale 1ns / 1ps

package lss_pkg;

    // Set length limit and the widths that follow from it
    localparam int MAX_POINTS = 1024;
    localparam int SMP_W      = 16;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int SX_W       = SMP_W + CNT_W - 1;
    localparam int SXY_W      = 2 * SMP_W + CNT_W - 1;

    // Numerator/denominator width and shared unit width (room for rem << 1)
    localparam int NUM_W  = CNT_W + SXY_W + 1;
    localparam int AW     = NUM_W + 2;
    localparam int FRAC_W = 16;
    localparam int DIV_W  = AW + FRAC_W;
    localparam int STEP_W = $clog2(DIV_W);

    // Result field widths
    localparam int SLOPE_W     = 48;
    localparam int MEAN_W      = 32;
    localparam int CNT_OUT_W   = 11;

    localparam logic [CNT_W-1:0]   COUNT_MAX     = CNT_W'(MAX_POINTS);
    localparam logic [SLOPE_W-1:0] SLOPE_POS_LIM = {1'b0, {(SLOPE_W - 1){1'b1}}};
    localparam logic [SLOPE_W-1:0] SLOPE_NEG_LIM = {1'b1, {(SLOPE_W - 1){1'b0}}};

    // Running sums of the current set
    typedef struct packed {
        logic [CNT_W-1:0]        count;
        logic signed [SX_W-1:0]  sum_x;
        logic signed [SX_W-1:0]  sum_y;
        logic signed [SXY_W-1:0] sum_xy;
        logic [SXY_W-1:0]        sum_xx;
    } sums_t;

    // One finished result
    typedef struct packed {
        logic signed [SLOPE_W-1:0] slope;
        logic signed [MEAN_W-1:0]  mean_x;
        logic signed [MEAN_W-1:0]  mean_y;
        logic [CNT_OUT_W-1:0]      point_count;
        logic                      degenerate;
    } result_t;

    // Request to the shared add/subtract unit
    typedef struct packed {
        logic [AW-1:0] a;
        logic [AW-1:0] b;
        logic          sub;
    } alu_req_t;

    // Sequencer status toward the top level
    typedef struct packed {
        logic idle;
        logic done;
    } seq_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_NUM_P,
        ST_NUM_Q,
        ST_DEN_P,
        ST_DEN_Q,
        ST_ABS,
        ST_DIV,
        ST_SIGN
    } seq_state_t;

    typedef enum logic [1:0] {
        JOB_SLOPE,
        JOB_MEAN_X,
        JOB_MEAN_Y,
        JOB_DONE
    } job_t;

endpackage

[src/lss_in_if.sv]
`timescale 1ns / 1ps

interface lss_in_if import lss_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [SMP_W-1:0]  x_sample;
    logic signed [SMP_W-1:0]  y_sample;
    logic                     last_point;

    modport source (output valid, output x_sample, output y_sample, output last_point,
                    input ready);
    modport sink (input valid, input x_sample, input y_sample, input last_point,
                  output ready);
endinterface

[src/lss_out_if.sv]
`timescale 1ns / 1ps

interface lss_out_if import lss_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [SLOPE_W-1:0] slope;
    logic signed [MEAN_W-1:0]  mean_x;
    logic signed [MEAN_W-1:0]  mean_y;
    logic [CNT_OUT_W-1:0]      point_count;
    logic                      degenerate;

    modport source (output valid, output slope, output mean_x, output mean_y,
                    output point_count, output degenerate, input ready);
    modport sink (input valid, input slope, input mean_x, input mean_y,
                  input point_count, input degenerate, output ready);
endinterface

[src/lss_accum.sv]
`timescale 1ns / 1ps

module lss_accum import lss_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    take,
    input  logic                    clear,
    input  logic signed [SMP_W-1:0] x_sample,
    input  logic signed [SMP_W-1:0] y_sample,
    output sums_t                   sums
);

    logic [CNT_W-1:0]        count_reg, count_next;
    logic signed [SX_W-1:0]  sum_x_reg, sum_x_next;
    logic signed [SX_W-1:0]  sum_y_reg, sum_y_next;
    logic signed [SXY_W-1:0] sum_xy_reg, sum_xy_next;
    logic [SXY_W-1:0]        sum_xx_reg, sum_xx_next;
    logic signed [2*SMP_W-1:0] prod_xy;
    logic signed [2*SMP_W-1:0] prod_xx;
    logic                    room;

    // Per-item products
    assign prod_xy = x_sample * y_sample;
    assign prod_xx = x_sample * x_sample;
    assign room    = count_reg < COUNT_MAX;

    // Sum update; pairs past the set limit are dropped
    always_comb
    begin
        count_next  = count_reg;
        sum_x_next  = sum_x_reg;
        sum_y_next  = sum_y_reg;
        sum_xy_next = sum_xy_reg;
        sum_xx_next = sum_xx_reg;
        if (clear)
        begin
            count_next  = '0;
            sum_x_next  = '0;
            sum_y_next  = '0;
            sum_xy_next = '0;
            sum_xx_next = '0;
        end
        else if (take && room)
        begin
            count_next  = count_reg + CNT_W'(1);
            sum_x_next  = sum_x_reg + SX_W'(x_sample);
            sum_y_next  = sum_y_reg + SX_W'(y_sample);
            sum_xy_next = sum_xy_reg + SXY_W'(prod_xy);
            sum_xx_next = sum_xx_reg + SXY_W'($unsigned(prod_xx));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            sum_xy_reg <= '0;
            sum_xx_reg <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            sum_x_reg  <= sum_x_next;
            sum_y_reg  <= sum_y_next;
            sum_xy_reg <= sum_xy_next;
            sum_xx_reg <= sum_xx_next;
        end
    end

    assign sums.count  = count_reg;
    assign sums.sum_x  = sum_x_reg;
    assign sums.sum_y  = sum_y_reg;
    assign sums.sum_xy = sum_xy_reg;
    assign sums.sum_xx = sum_xx_reg;

endmodule

[src/lss_addsub.sv]
`timescale 1ns / 1ps

module lss_addsub import lss_pkg::*; (
    input  alu_req_t      req,
    output logic [AW-1:0] y
);

    // The one wide adder shared by every multiply, divide and negate step
    assign y = req.sub ? (req.a - req.b) : (req.a + req.b);

endmodule

[src/lss_seq.sv]
`timescale 1ns / 1ps

module lss_seq import lss_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      out_free,
    input  sums_t     sums,
    output result_t   result,
    output seq_stat_t stat
);

    seq_state_t           state_reg, state_next;
    job_t                 job_reg, job_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [AW-1:0]        acc_reg, acc_next;
    logic [AW-1:0]        mcand_reg, mcand_next;
    logic [SX_W-1:0]      mplier_reg, mplier_next;
    logic [AW-1:0]        num_reg, num_next;
    logic [AW-1:0]        den_reg, den_next;
    logic [AW-1:0]        div_reg, div_next;
    logic [DIV_W-1:0]     qd_reg, qd_next;
    logic                 neg_reg, neg_next;
    logic [SLOPE_W-1:0]   slope_reg, slope_next;
    logic [MEAN_W-1:0]    mean_x_reg, mean_x_next;
    logic [MEAN_W-1:0]    mean_y_reg, mean_y_next;

    alu_req_t             alu_req;
    logic [AW-1:0]        alu_y;
    logic                 last_step;
    logic [AW-1:0]        mul_b;
    logic [AW-1:0]        op_sel;
    logic [AW-1:0]        div_sel;
    logic                 op_neg;
    logic [AW-1:0]        rem_sh;
    logic                 trial_ge;
    logic [SLOPE_W-1:0]   slope_lim;
    logic                 q_over;
    logic [SLOPE_W-1:0]   sat_val;
    logic [AW-1:0]        sign_val;
    logic [AW-1:0]        sign_res;
    logic                 den_zero;
    logic                 seq_done;

    lss_addsub u_addsub (
        .req (alu_req),
        .y   (alu_y)
    );

    assign last_step = (step_reg == '0);
    assign den_zero  = (den_reg == '0);

    // Shift-add multiply: add the shifted multiplicand when the multiplier bit is set
    assign mul_b = mplier_reg[0] ? mcand_reg : '0;

    // Operand and divisor of the current division job
    always_comb
    begin
        case (job_reg)
            JOB_SLOPE:
            begin
                op_sel  = num_reg;
                div_sel = den_reg;
            end
            JOB_MEAN_X:
            begin
                op_sel  = AW'($signed(sums.sum_x));
                div_sel = AW'(sums.count);
            end
            JOB_MEAN_Y:
            begin
                op_sel  = AW'($signed(sums.sum_y));
                div_sel = AW'(sums.count);
            end
            default:
            begin
                op_sel  = '0;
                div_sel = AW'(sums.count);
            end
        endcase
    end
    assign op_neg = op_sel[AW-1];

    // Restoring division step: shift in the next dividend bit, trial subtract
    assign rem_sh   = {acc_reg[AW-2:0], qd_reg[DIV_W-1]};
    assign trial_ge = !alu_y[AW-1];

    // Slope saturation on the finished quotient magnitude
    assign slope_lim = neg_reg ? SLOPE_NEG_LIM : SLOPE_POS_LIM;
    assign q_over    = (|qd_reg[DIV_W-1:SLOPE_W]) || (qd_reg[SLOPE_W-1:0] > slope_lim);
    assign sat_val   = q_over ? slope_lim : qd_reg[SLOPE_W-1:0];
    assign sign_val  = (job_reg == JOB_SLOPE) ? AW'(sat_val) : qd_reg[AW-1:0];
    assign sign_res  = neg_reg ? alu_y : sign_val;

    // Shared unit operand select
    always_comb
    begin
        alu_req.a   = acc_reg;
        alu_req.b   = '0;
        alu_req.sub = 1'b0;
        unique case (state_reg)
            ST_NUM_P, ST_DEN_P:
            begin
                alu_req.b = mul_b;
            end
            ST_NUM_Q, ST_DEN_Q:
            begin
                // signed multiplier: its top bit carries negative weight
                alu_req.b   = mul_b;
                alu_req.sub = !last_step;
            end
            ST_ABS:
            begin
                alu_req.a   = '0;
                alu_req.b   = op_sel;
                alu_req.sub = 1'b1;
            end
            ST_DIV:
            begin
                alu_req.a   = rem_sh;
                alu_req.b   = div_reg;
                alu_req.sub = 1'b1;
            end
            ST_SIGN:
            begin
                alu_req.a   = '0;
                alu_req.b   = sign_val;
                alu_req.sub = 1'b1;
            end
            default:
            begin
                alu_req.a = acc_reg;
            end
        endcase
    end

    // Sequencer: numerator, denominator, then up to three divisions
    always_comb
    begin
        state_next  = state_reg;
        job_next    = job_reg;
        step_next   = step_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        num_next    = num_reg;
        den_next    = den_reg;
        div_next    = div_reg;
        qd_next     = qd_reg;
        neg_next    = neg_reg;
        slope_next  = slope_reg;
        mean_x_next = mean_x_reg;
        mean_y_next = mean_y_reg;
        seq_done    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                // the closing pair lands in the sums at this edge
                if (start)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next  = ST_NUM_P;
                acc_next    = '0;
                mcand_next  = AW'($signed(sums.sum_xy));
                mplier_next = SX_W'(sums.count);
                step_next   = STEP_W'(CNT_W - 1);
            end
            ST_NUM_P, ST_NUM_Q, ST_DEN_P, ST_DEN_Q:
            begin
                acc_next    = alu_y;
                mcand_next  = {mcand_reg[AW-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[SX_W-1:1]};
                step_next   = step_reg - STEP_W'(1);
                if (last_step)
                begin
                    case (state_reg)
                        ST_NUM_P:
                        begin
                            // acc holds n*Sxy; now subtract Sx*Sy
                            state_next  = ST_NUM_Q;
                            mcand_next  = AW'($signed(sums.sum_x));
                            mplier_next = sums.sum_y;
                            step_next   = STEP_W'(SX_W - 1);
                        end
                        ST_NUM_Q:
                        begin
                            state_next  = ST_DEN_P;
                            num_next    = alu_y;
                            acc_next    = '0;
                            mcand_next  = AW'(sums.sum_xx);
                            mplier_next = SX_W'(sums.count);
                            step_next   = STEP_W'(CNT_W - 1);
                        end
                        ST_DEN_P:
                        begin
                            state_next  = ST_DEN_Q;
                            mcand_next  = AW'($signed(sums.sum_x));
                            mplier_next = sums.sum_x;
                            step_next   = STEP_W'(SX_W - 1);
                        end
                        default:
                        begin
                            state_next = ST_ABS;
                            den_next   = alu_y;
                            job_next   = JOB_SLOPE;
                        end
                    endcase
                end
            end
            ST_ABS:
            begin
                if (job_reg == JOB_SLOPE && den_zero)
                begin
                    // all x equal: slope forced to zero, no division
                    slope_next = '0;
                    job_next   = JOB_MEAN_X;
                end
                else
                begin
                    state_next = ST_DIV;
                    neg_next   = op_neg;
                    acc_next   = '0;
                    qd_next    = {(op_neg ? alu_y : op_sel), {FRAC_W{1'b0}}};
                    div_next   = div_sel;
                    step_next  = STEP_W'(DIV_W - 1);
                end
            end
            ST_DIV:
            begin
                acc_next  = trial_ge ? alu_y : rem_sh;
                qd_next   = {qd_reg[DIV_W-2:0], trial_ge};
                step_next = step_reg - STEP_W'(1);
                if (last_step)
                begin
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN:
            begin
                case (job_reg)
                    JOB_SLOPE:
                    begin
                        slope_next = sign_res[SLOPE_W-1:0];
                        job_next   = JOB_MEAN_X;
                        state_next = ST_ABS;
                    end
                    JOB_MEAN_X:
                    begin
                        mean_x_next = sign_res[MEAN_W-1:0];
                        job_next    = JOB_MEAN_Y;
                        state_next  = ST_ABS;
                    end
                    default:
                    begin
                        mean_y_next = sign_res[MEAN_W-1:0];
                        job_next    = JOB_DONE;
                    end
                endcase
            end
            default:
            begin
                // unused state codes fall back to idle
                state_next = ST_IDLE;
            end
        endcase

        // Hold in SIGN after the last job until the output register can take it
        if (state_reg == ST_SIGN && job_reg == JOB_DONE)
        begin
            state_next = out_free ? ST_IDLE : ST_SIGN;
            seq_done   = out_free;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            job_reg   <= JOB_SLOPE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            job_reg   <= job_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        div_reg    <= div_next;
        qd_reg     <= qd_next;
        neg_reg    <= neg_next;
        slope_reg  <= slope_next;
        mean_x_reg <= mean_x_next;
        mean_y_reg <= mean_y_next;
    end

    assign stat.idle          = (state_reg == ST_IDLE);
    assign stat.done          = seq_done;
    assign result.slope       = slope_reg;
    assign result.mean_x      = mean_x_reg;
    assign result.mean_y      = mean_y_reg;
    assign result.point_count = CNT_OUT_W'(sums.count);
    assign result.degenerate  = den_zero;

endmodule

[src/least_squares_slope_core.sv]
`timescale 1ns / 1ps

// Least-squares line fit over sets of (x, y) pairs. Pairs are taken one item per
// cycle and added to a count and to the sums of x, y, x*y and x*x; pairs past
// MAX_POINTS in one set are dropped. The item marked last_point closes the set:
// the block then stops taking items until its result has entered the output
// register, also waiting while the previous result is still held there. A load state
// and one 56-bit add/subtract unit do the work: the unit forms n*Sxy - Sx*Sy and
// n*Sxx - Sx*Sx by shift-add multiplies, then runs up to three restoring divisions
// of 72 steps, one quotient bit per cycle, for the Q32.16 slope (truncated toward
// zero, saturated to 48 bits) and the two Q16.16 means. A zero denominator gives
// slope 0 with degenerate set. The sums clear as the result enters the output
// register, which holds it until taken while the next set already accumulates.
module least_squares_slope_core import lss_pkg::*; (
    input logic       clk,
    input logic       rst_n,
    lss_in_if.sink    samples,
    lss_out_if.source results
);

    sums_t     sums;
    result_t   result;
    seq_stat_t stat;
    logic      take;
    logic      start;
    logic      out_free;
    logic      out_valid_reg, out_valid_next;
    result_t   out_data_reg;

    // Input handshake: items only while the sequencer is idle
    assign samples.ready = stat.idle;
    assign take          = samples.valid && samples.ready;
    assign start         = take && samples.last_point;
    assign out_free      = !out_valid_reg || results.ready;

    lss_accum u_accum (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .clear    (stat.done),
        .x_sample (samples.x_sample),
        .y_sample (samples.y_sample),
        .sums     (sums)
    );

    lss_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .out_free (out_free),
        .sums     (sums),
        .result   (result),
        .stat     (stat)
    );

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (stat.done)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.done)
        begin
            out_data_reg <= result;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.slope       = out_data_reg.slope;
    assign results.mean_x      = out_data_reg.mean_x;
    assign results.mean_y      = out_data_reg.mean_y;
    assign results.point_count = out_data_reg.point_count;
    assign results.degenerate  = out_data_reg.degenerate;

endmodule
